### rtl/smt_pkg.sv
// Shared types, widths and codes for the smoothed frame timer.
package smt_pkg;

  localparam int DUR_W    = 25;  // signed frame duration
  localparam int SUM_W    = 30;  // signed running sum over up to 31 durations
  localparam int GAME_W   = 64;
  localparam int CNT_W    = 32;
  localparam int WIN_W    = 5;
  localparam int MAXT_W   = 24;
  localparam int REG_TIME_W = 48;  // widest time value the start register keeps
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_HISTORY_DEPTH = 16;
  localparam int DEF_TIME_WIDTH    = 48;

  localparam logic [WIN_W-1:0]  WINDOW_RST   = 5'd1;
  localparam logic [MAXT_W-1:0] MAX_TIME_RST = 24'd100000;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CLAMP,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;  // take the sample of an accepted item
    logic diff;     // raw elapsed time, ring read
    logic clamp;    // saturate elapsed time
    logic update;   // ring write, running sum, head and fill
    logic load;     // start the divider
    logic step;     // one divider iteration
    logic finish;   // restore the quotient sign
    logic commit;   // publish the result and advance game time
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

### rtl/smt_ctrl.sv
// Sequencing state machine and result-valid flag of the smoothed frame timer.
module smt_ctrl
  import smt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_CLAMP;
      ST_CLAMP:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (status.div_last) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_COMMIT;
      ST_COMMIT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DIFF:   cmd.diff   = 1'b1;
      ST_CLAMP:  cmd.clamp  = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_LOAD:   cmd.load   = 1'b1;
      ST_DIVIDE: cmd.step   = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      ST_COMMIT: cmd.commit = out_free;
      default:   cmd        = '0;
    endcase
  end

  // The result register is released by out_ready and refilled by a commit.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/smt_datapath.sv
// Datapath: configuration, elapsed-time clamp, duration ring, serial divider, totals.
module smt_datapath
  import smt_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int TIME_WIDTH    = DEF_TIME_WIDTH,
  parameter int CFG_W         = (TIME_WIDTH > MAXT_W) ? TIME_WIDTH : MAXT_W
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [TIME_WIDTH-1:0]    in_sample_time,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  output logic signed [DUR_W-1:0]  out_frame_duration,
  output logic signed [GAME_W-1:0] out_game_time,
  output logic [CNT_W-1:0]         out_frame_count
);

  localparam int TW      = (TIME_WIDTH < REG_TIME_W) ? TIME_WIDTH : REG_TIME_W;
  localparam int CMP_W   = ((TW > MAXT_W) ? TW : MAXT_W) + 1;
  localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int WIN_CAP = (HISTORY_DEPTH < 31) ? HISTORY_DEPTH : 31;
  localparam int DCNT_W  = $clog2(SUM_W);

  // Configuration registers.
  logic [WIN_W-1:0]  window_r;
  logic [MAXT_W-1:0] max_time_r;
  logic [TW-1:0]     prev_r;

  // Per-item working registers.
  logic [TW-1:0]            now_r;
  logic signed [TW:0]       diff_r;
  logic signed [DUR_W-1:0]  elapsed_r;
  logic signed [DUR_W-1:0]  rd_r;
  logic [IDX_W-1:0]         head_r;
  logic [WIN_W-1:0]         fill_r;
  logic signed [SUM_W-1:0]  sum_r;

  // Divider.
  logic [SUM_W-1:0]  dq_r;
  logic [WIN_W-1:0]  rem_r;
  logic [WIN_W-1:0]  divisor_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              neg_r;

  logic signed [DUR_W-1:0]  avg_r;
  logic signed [DUR_W-1:0]  dur_out_r;
  logic signed [GAME_W-1:0] game_r;
  logic [CNT_W-1:0]         count_r;

  logic signed [DUR_W-1:0] ring_mem [HISTORY_DEPTH];

  logic [WIN_W-1:0]        win;
  logic [TW:0]             mag;
  logic                    over;
  logic [MAXT_W-1:0]       emag;
  logic signed [DUR_W-1:0] old_val;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [WIN_W:0]          head_inc;
  logic [IDX_W-1:0]        head_nxt;
  logic [WIN_W-1:0]        fill_nxt;
  logic [WIN_W:0]          rs;
  logic                    ge;
  logic [SUM_W-1:0]        sum_mag;

  always_comb begin
    if (window_r == '0) begin
      win = WIN_W'(1);
    end else if (window_r > WIN_W'(WIN_CAP)) begin
      win = WIN_W'(WIN_CAP);
    end else begin
      win = window_r;
    end
  end

  assign mag  = diff_r[TW] ? TW'(-diff_r) : TW'(diff_r);
  assign over = CMP_W'(mag) > CMP_W'(max_time_r);
  assign emag = over ? max_time_r : MAXT_W'(mag);

  // A slot is only valid once the ring has filled since the last window change.
  assign old_val  = (fill_r == win) ? rd_r : '0;
  assign sum_nxt  = sum_r - SUM_W'(old_val) + SUM_W'(elapsed_r);
  assign head_inc = (WIN_W + 1)'(head_r) + 1'b1;
  assign head_nxt = (head_inc >= {1'b0, win}) ? '0 : IDX_W'(head_inc);
  assign fill_nxt = (fill_r < win) ? fill_r + 1'b1 : win;

  assign rs      = {rem_r, dq_r[SUM_W-1]};
  assign ge      = rs >= {1'b0, divisor_r};
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  assign status.div_last = (dcnt_r == '0);

  // Configuration and history control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RST;
      max_time_r <= MAX_TIME_RST;
      prev_r     <= '0;
      head_r     <= '0;
      fill_r     <= '0;
      sum_r      <= '0;
      game_r     <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW: begin
            window_r <= cfg_wdata[WIN_W-1:0];
            head_r   <= '0;
            fill_r   <= '0;
            sum_r    <= '0;
          end
          REG_MAX_TIME:   max_time_r <= cfg_wdata[MAXT_W-1:0];
          REG_START_TIME: prev_r     <= cfg_wdata[TW-1:0];
          default: ;
        endcase
      end
      if (cmd.diff) begin
        prev_r <= now_r;
      end
      if (cmd.update) begin
        sum_r  <= sum_nxt;
        head_r <= head_nxt;
        fill_r <= fill_nxt;
      end
      if (cmd.commit) begin
        game_r  <= game_r + GAME_W'(avg_r);
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Duration ring: one registered read and one write at the head slot.
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      rd_r <= ring_mem[head_r];
    end
    if (cmd.update) begin
      ring_mem[head_r] <= elapsed_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r <= in_sample_time[TW-1:0];
    end
    if (cmd.diff) begin
      diff_r <= $signed({1'b0, now_r}) - $signed({1'b0, prev_r});
    end
    if (cmd.clamp) begin
      elapsed_r <= diff_r[TW] ? -$signed({1'b0, emag}) : $signed({1'b0, emag});
    end
    if (cmd.load) begin
      dq_r      <= sum_mag;
      rem_r     <= '0;
      divisor_r <= fill_r;
      neg_r     <= sum_r[SUM_W-1];
      dcnt_r    <= DCNT_W'(SUM_W - 1);
    end else if (cmd.step) begin
      dq_r   <= {dq_r[SUM_W-2:0], ge};
      rem_r  <= ge ? WIN_W'(rs - {1'b0, divisor_r}) : WIN_W'(rs);
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.finish) begin
      avg_r <= neg_r ? -$signed(DUR_W'(dq_r)) : $signed(DUR_W'(dq_r));
    end
    if (cmd.commit) begin
      dur_out_r <= avg_r;
    end
  end

  assign out_frame_duration = dur_out_r;
  assign out_game_time      = game_r;
  assign out_frame_count    = count_r;

endmodule

### rtl/smoothed_frame_timer.sv
// Top level of the smoothed frame timer: controller, datapath and checks.
//
//   channel  direction  handshake                 payload
//   in_      input      in_valid / in_ready       in_sample_time
//   out_     output     out_valid / out_ready     out_frame_duration, out_game_time,
//                                                 out_frame_count
//   cfg_     input      cfg_we                    cfg_index, cfg_wdata
//
// Each item passes through the difference, clamp, update, load, divide, finish and commit
// states, the 30-step serial divider being the longest; a new item is taken only after the previous one is committed.
// A result waits in the output register while the next item is already accepted.
// Reset is synchronous and active low; the duration ring needs no clearing pass.
// A stalled result holds the commit step until out_ready frees the output register.
module smoothed_frame_timer
  import smt_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int TIME_WIDTH    = DEF_TIME_WIDTH,
  parameter int CFG_W         = (TIME_WIDTH > MAXT_W) ? TIME_WIDTH : MAXT_W
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TIME_WIDTH-1:0]    in_sample_time,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DUR_W-1:0]  out_frame_duration,
  output logic signed [GAME_W-1:0] out_game_time,
  output logic [CNT_W-1:0]         out_frame_count
);

  dp_cmd_t    cmd;
  dp_status_t status;

  smt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  smt_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TIME_WIDTH    (TIME_WIDTH),
    .CFG_W         (CFG_W)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_sample_time     (in_sample_time),
    .cmd                (cmd),
    .status             (status),
    .out_frame_duration (out_frame_duration),
    .out_game_time      (out_game_time),
    .out_frame_count    (out_frame_count)
  );

  // After an item is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an item was accepted");

  // The frame counter only ever advances by one.
  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_frame_count != $past(out_frame_count)) |->
      (out_frame_count == $past(out_frame_count) + 32'd1))
    else $error("frame count moved by other than one");

  // A new result appears only together with a valid flag.
  a_count_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_frame_count != $past(out_frame_count)) |-> out_valid)
    else $error("frame count changed without a valid result");

endmodule

### test/smoothed_frame_timer_test.sv
// Self-checking testbench for the smoothed frame timer with a built-in predictor.
module smoothed_frame_timer_test;
  import smt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unused index, writes are ignored
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 60;
  localparam int CALM_FIRST    = 2000;
  localparam int CALM_LAST     = 6000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 72;

  typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_WAIT} timer_op_kind_t;

  typedef struct {
    timer_op_kind_t         kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [REG_TIME_W-1:0]  data;
  } timer_op_t;

  typedef struct packed {
    logic signed [DUR_W-1:0]  duration;
    logic signed [GAME_W-1:0] game;
    logic [CNT_W-1:0]         count;
  } frame_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [REG_TIME_W-1:0]    cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [REG_TIME_W-1:0]    in_sample_time = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DUR_W-1:0]  out_frame_duration;
  logic signed [GAME_W-1:0] out_game_time;
  logic [CNT_W-1:0]         out_frame_count;

  smoothed_frame_timer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_time     (in_sample_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_duration (out_frame_duration),
    .out_game_time      (out_game_time),
    .out_frame_count    (out_frame_count)
  );

  // Predictor state and its copy of the registers.
  logic [WIN_W-1:0]         window_reg = WINDOW_RST;
  logic [MAXT_W-1:0]        max_time_reg = MAX_TIME_RST;
  logic [REG_TIME_W-1:0]    last_sample = '0;
  longint                   duration_ring [DEF_HISTORY_DEPTH];
  int                       ring_head = 0;
  int                       fill_count = 0;
  longint                   duration_sum = 0;
  logic signed [GAME_W-1:0] game_acc = '0;
  logic [CNT_W-1:0]         frame_no = '0;

  timer_op_t     pending_q[$];
  frame_result_t expected_q[$];
  int            items_sent = 0;
  int            results_seen = 0;
  int            quiet_cycles = 0;
  int            cycle_no = 0;
  int            errors = 0;
  logic          calm;

  // Stimulus generator bookkeeping.
  logic [REG_TIME_W-1:0] gen_prev = '0;
  int unsigned           gen_max = 32'(MAX_TIME_RST);

  assign calm = (cycle_no >= CALM_FIRST) && (cycle_no < CALM_LAST);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void clear_history();
    foreach (duration_ring[i]) duration_ring[i] = 0;
    ring_head = 0;
    fill_count = 0;
    duration_sum = 0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [REG_TIME_W-1:0] data);
    case (idx)
      REG_WINDOW: begin
        window_reg = data[WIN_W-1:0];
        clear_history();
      end
      REG_MAX_TIME:   max_time_reg = data[MAXT_W-1:0];
      REG_START_TIME: last_sample = data;
      default: ;
    endcase
  endfunction

  function automatic frame_result_t advance_timer(logic [REG_TIME_W-1:0] now);
    longint        diff;
    longint        limit;
    longint        avg;
    int            win;
    int            slot;
    frame_result_t r;
    win = int'(window_reg);
    if (win < 1) win = 1;
    if (win > DEF_HISTORY_DEPTH) win = DEF_HISTORY_DEPTH;
    limit = longint'(max_time_reg);
    // Elapsed time saturates at the maximum in either direction.
    diff = longint'(now) - longint'(last_sample);
    if (diff > limit) diff = limit;
    if (diff < -limit) diff = -limit;
    last_sample = now;
    slot = (ring_head >= win) ? 0 : ring_head;
    duration_sum = duration_sum - duration_ring[slot] + diff;
    duration_ring[slot] = diff;
    ring_head = (slot + 1 >= win) ? 0 : slot + 1;
    if (fill_count < win) fill_count++;
    if (fill_count > win) fill_count = win;
    avg = duration_sum / longint'(fill_count);
    game_acc = game_acc + avg;
    frame_no = frame_no + 1'b1;
    r.duration = avg[DUR_W-1:0];
    r.game = game_acc;
    r.count = frame_no;
    return r;
  endfunction

  function automatic logic [REG_TIME_W-1:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  task automatic queue_sample(logic [REG_TIME_W-1:0] t);
    timer_op_t op;
    op.kind = OP_SAMPLE;
    op.idx = '0;
    op.data = t;
    pending_q.push_back(op);
    gen_prev = t;
  endtask

  task automatic queue_write(logic [CFG_IDX_W-1:0] idx, logic [REG_TIME_W-1:0] data);
    timer_op_t op;
    op.kind = OP_WRITE;
    op.idx = idx;
    op.data = data;
    pending_q.push_back(op);
    if (idx == REG_MAX_TIME) gen_max = 32'(data[MAXT_W-1:0]);
    if (idx == REG_START_TIME) gen_prev = data;
  endtask

  task automatic queue_wait();
    timer_op_t op;
    op.kind = OP_WAIT;
    op.idx = '0;
    op.data = '0;
    pending_q.push_back(op);
  endtask

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Driver: one operation from the pending queue per cycle at most.
  always @(posedge clk) begin
    timer_op_t op;
    logic      next_valid;
    logic      next_we;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      next_valid = in_valid;
      next_we = 1'b0;
      if (in_valid && in_ready) begin
        expected_q.push_back(advance_timer(in_sample_time));
        items_sent <= items_sent + 1;
        next_valid = 1'b0;
      end
      if (!in_valid && items_sent == results_seen)
        quiet_cycles <= quiet_cycles + 1;
      else
        quiet_cycles <= 0;
      if (!next_valid && pending_q.size() > 0) begin
        op = pending_q[0];
        if (op.kind == OP_SAMPLE) begin
          if (calm || $urandom_range(99) >= 6) begin
            in_sample_time <= op.data;
            next_valid = 1'b1;
            void'(pending_q.pop_front());
          end
        end else if (!in_valid && quiet_cycles >= SETTLE_CYCLES) begin
          // Register writes and pauses only go ahead once every result is back.
          if (op.kind == OP_WRITE) begin
            next_we = 1'b1;
            cfg_index <= op.idx;
            cfg_wdata <= op.data;
            apply_register(op.idx, op.data);
          end
          void'(pending_q.pop_front());
        end
      end
      in_valid <= next_valid;
      cfg_we <= next_we;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("result item with no prediction waiting: count %0d", out_frame_count);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_frame_duration !== want.duration) begin
            $error("frame_duration: expected %0d, got %0d", want.duration,
                   out_frame_duration);
            errors++;
          end
          if (out_game_time !== want.game) begin
            $error("game_time: expected %0d, got %0d", want.game, out_game_time);
            errors++;
          end
          if (out_frame_count !== want.count) begin
            $error("frame_count: expected %0d, got %0d", want.count, out_frame_count);
            errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    logic [REG_TIME_W-1:0] w;
    logic [REG_TIME_W-1:0] t;
    int unsigned           pick;
    foreach (duration_ring[i]) duration_ring[i] = 0;

    // Directed part: field extremes, clamping both ways and register corners.
    queue_sample('0);
    queue_sample(48'd1000);
    queue_sample(48'd500000);
    queue_sample(48'd400000);
    queue_sample(48'd399990);
    queue_sample('1);
    queue_sample('0);
    queue_write(REG_WINDOW, 48'd4);
    queue_sample(48'd100);
    queue_sample(48'd50);
    queue_sample(48'd40);
    queue_sample(48'd41);
    queue_sample(48'd45);
    queue_write(REG_MAX_TIME, 48'd0);
    queue_sample(48'd1000000);
    queue_sample(48'd5);
    queue_write(REG_MAX_TIME, 48'hFF_FFFF);
    queue_write(REG_WINDOW, 48'd0);
    queue_sample(48'd16777400);
    queue_sample('0);
    w = rand48();
    w[WIN_W-1:0] = 5'd31;
    queue_write(REG_WINDOW, w);
    queue_sample(48'd16777215);
    queue_sample(48'd33554430);
    queue_sample(48'd50331645);
    queue_sample(48'd20);
    queue_write(REG_START_TIME, 48'hFFFF_FFFF_FF00);
    queue_write(REG_SPARE, rand48());
    queue_sample('1);
    queue_sample('0);

    // Random phases, each starting from a quiet block, possibly with new register values.
    for (int p = 0; p < PHASES; p++) begin
      queue_wait();
      if ($urandom_range(9) < 6) begin
        w = rand48();
        case ($urandom_range(4))
          0: w[WIN_W-1:0] = 5'd0;
          1: w[WIN_W-1:0] = 5'd1;
          2: w[WIN_W-1:0] = 5'd16;
          3: w[WIN_W-1:0] = 5'd31;
          default: w[WIN_W-1:0] = 5'($urandom_range(31));
        endcase
        queue_write(REG_WINDOW, w);
      end
      if ($urandom_range(9) < 6) begin
        w = rand48();
        case ($urandom_range(5))
          0: w[MAXT_W-1:0] = '0;
          1: w[MAXT_W-1:0] = '1;
          2: w[MAXT_W-1:0] = 24'($urandom());
          default: w[MAXT_W-1:0] = 24'($urandom_range(60000, 2000));
        endcase
        queue_write(REG_MAX_TIME, w);
      end
      if ($urandom_range(3) == 0)
        queue_write(REG_START_TIME, ($urandom_range(1) == 0) ? rand48() : gen_prev - 48'd7);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 70)
          t = gen_prev + $urandom_range(gen_max + gen_max / 4 + 10);
        else if (pick < 80)
          t = gen_prev - $urandom_range(gen_max / 2 + 10);
        else if (pick < 86)
          t = gen_prev;
        else if (pick < 94)
          t = rand48();
        else
          t = 48'hFFFF_FFFF_FFFF - $urandom_range(255);
        queue_sample(t);
        if ($urandom_range(49) == 0) queue_wait();
      end
    end

    while (pending_q.size() > 0 || in_valid || results_seen != items_sent)
      @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (expected_q.size() != 0)
        $error("%0d predicted result items never arrived", expected_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
